>>> src/lbf_pkg.sv
`default_nettype none
package lbf_pkg;

    // Strip length; a pixel index at or beyond it is dark
    localparam int unsigned PIXELS_DEF        = 1024;
    localparam int unsigned EASE_BITS_DEF     = 8;

    // Register widths
    localparam int unsigned CFG_DATA_W        = 50;
    localparam int unsigned CFG_INDEX_W       = 3;

    // pi in Q2.30
    localparam logic [63:0] PI_Q30            = 64'd3373259426;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BREATH_START  = 3'd0,
        CFG_BREATH_SHAPE  = 3'd1,
        CFG_BREATH_LEVELS = 3'd2,
        CFG_FLICKER_START = 3'd3,
        CFG_FLICKER_SHAPE = 3'd4,
        CFG_FLICKER_COLOR = 3'd5,
        CFG_GROUPING      = 3'd6
    } t_cfg_idx;

    // Unsigned long division by shift and subtract, for constant tables only
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // One ease table entry: Q0.16 of sin^2(pi*i/(2*last)), series for sin
    function automatic logic [15:0] ease_entry(input int unsigned idx,
                                               input int unsigned last);
        logic [63:0] phi;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] sq;
        logic [63:0] e;
        logic [63:0] dv;
        phi  = udiv64(PI_Q30 * 64'(idx), 64'd2 * 64'(last));
        x2   = (phi * phi) >> 30;
        term = phi;
        sum  = phi;
        for (int k = 1; k <= 8; k++) begin
            dv   = 64'(2 * k) * 64'(2 * k + 1);
            term = udiv64((term * x2) >> 30, dv);
            if ((k % 2) == 1) begin
                sum = (sum > term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        sq = sum * sum;
        e  = (sq + (64'd1 << 43)) >> 44;
        return (e > 64'd65535) ? 16'hFFFF : e[15:0];
    endfunction

endpackage
`default_nettype wire

>>> src/led_breath_flicker_pixel_color.sv
`default_nettype none
// Pixel colour for a breathing LED strip with a flicker gate. Each transfer
// on the input channel carries a millisecond time stamp and a pixel index;
// one colour transfer comes out for each, in order. The block keeps no state
// between items and takes one item per clock while the output is not stalled;
// the pipeline holds a 32-step remainder chain for the breath and flicker
// phases and an EASE_TABLE_BITS-step ease-index divider.
// A stall on the output holds the whole pipeline. Registers are written
// through the configuration channel, which is always ready; write them only
// while no item is in flight.
module led_breath_flicker_pixel_color #(
    parameter int unsigned EASE_TABLE_BITS = lbf_pkg::EASE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [lbf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [lbf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [31:0]                    i_now_ms,
    input  wire logic [9:0]                     i_pixel_index,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [7:0]                          o_red,
    output logic [7:0]                          o_green,
    output logic [7:0]                          o_blue
);
    import lbf_pkg::*;

    localparam int unsigned EB      = EASE_TABLE_BITS;
    localparam int unsigned EASE_N  = 1 << EB;
    localparam int unsigned NUMW    = 18 + EB;
    localparam int unsigned ST_DIV0 = 2;
    localparam int unsigned ST_PH   = ST_DIV0 + 32;
    localparam int unsigned ST_Q0   = ST_PH + 1;
    localparam int unsigned ST_IDX  = ST_Q0 + EB;
    localparam int unsigned ST_LVL  = ST_IDX + 1;
    localparam int unsigned ST_COL  = ST_LVL + 1;
    localparam int unsigned NST     = ST_COL + 1;
    localparam logic [15:0] PIX_LIM = 16'(PIXELS_DEF);

    typedef logic [15:0] t_rom [EASE_N];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int unsigned i = 0; i < EASE_N; i++) begin
            rom[i] = ease_entry(i, EASE_N - 1);
        end
        return rom;
    endfunction

    localparam t_rom EASE_ROM = build_rom();

    typedef struct packed {
        logic [31:0]     now;
        logic [9:0]      pix;
        logic            pix_ok;
        logic [31:0]     b_dvd;
        logic [16:0]     b_rem;
        logic            b_off;
        logic            b_min;
        logic [31:0]     f_dvd;
        logic [16:0]     f_rem;
        logic            f_fix;
        logic            f_fixval;
        logic [9:0]      p_dvd;
        logic [7:0]      p_rem;
        logic            rise;
        logic [NUMW-1:0] num;
        logic [16:0]     den;
        logic [EB-1:0]   q;
        logic [15:0]     entry;
        logic [24:0]     level;
        logic            gate;
        logic [7:0]      red;
        logic [7:0]      green;
        logic [7:0]      blue;
    } t_stage;

    // Configuration registers
    logic [31:0] r_b_start;
    logic [48:0] r_b_shape;
    logic [39:0] r_b_levels;
    logic [31:0] r_f_start;
    logic [49:0] r_f_shape;
    logic [23:0] r_f_color;
    logic [15:0] r_grouping;
    logic [32:0] r_b_lim;
    logic [32:0] r_f_lim;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_start  <= '0;
            r_b_shape  <= '0;
            r_b_levels <= '0;
            r_f_start  <= '0;
            r_f_shape  <= '0;
            r_f_color  <= 24'd127;
            r_grouping <= 16'd257;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BREATH_START:  r_b_start  <= i_cfg_data[31:0];
                CFG_BREATH_SHAPE:  r_b_shape  <= i_cfg_data[48:0];
                CFG_BREATH_LEVELS: r_b_levels <= i_cfg_data[39:0];
                CFG_FLICKER_START: r_f_start  <= i_cfg_data[31:0];
                CFG_FLICKER_SHAPE: r_f_shape  <= i_cfg_data[49:0];
                CFG_FLICKER_COLOR: r_f_color  <= i_cfg_data[23:0];
                CFG_GROUPING:      r_grouping <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Decoded fields
    logic [15:0] b_up, b_down, b_cyc, f_on, f_off, f_cyc;
    logic [16:0] b_per, f_per;
    logic        b_en, f_en, f_inv;
    logic [7:0]  lv_lo, lv_hi, br_r, br_g, br_b;
    logic [7:0]  grp_size, grp_lit;

    always_comb begin
        b_up     = r_b_shape[15:0];
        b_down   = r_b_shape[31:16];
        b_cyc    = r_b_shape[47:32];
        b_en     = r_b_shape[48];
        f_on     = r_f_shape[15:0];
        f_off    = r_f_shape[31:16];
        f_cyc    = r_f_shape[47:32];
        f_en     = r_f_shape[48];
        f_inv    = r_f_shape[49];
        b_per    = 17'(b_up) + 17'(b_down);
        f_per    = 17'(f_on) + 17'(f_off);
        lv_lo    = r_b_levels[7:0];
        lv_hi    = r_b_levels[15:8];
        br_r     = r_b_levels[23:16];
        br_g     = r_b_levels[31:24];
        br_b     = r_b_levels[39:32];
        grp_size = (r_grouping[7:0] == 8'd0) ? 8'd1 : r_grouping[7:0];
        grp_lit  = (r_grouping[15:8] == 8'd0) ? 8'd1 : r_grouping[15:8];
        if (grp_lit > grp_size) begin
            grp_lit = grp_size;
        end
    end

    // Cycle limits, products kept out of the item path
    always_ff @(posedge i_clk) begin
        r_b_lim <= 33'(b_cyc) * 33'(b_per);
        r_f_lim <= 33'(f_cyc) * 33'(f_per);
    end

    // Pipeline
    t_stage r_st [NST];
    t_stage n_st [NST];
    logic   r_vld [NST];
    logic   en;

    assign en      = !r_vld[NST-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NST-1];
    assign o_red   = r_st[NST-1].red;
    assign o_green = r_st[NST-1].green;
    assign o_blue  = r_st[NST-1].blue;

    always_comb begin
        t_stage           s;
        logic [17:0]      rw;
        logic [8:0]       pw;
        logic [16:0]      off17;
        logic [15:0]      dd;
        logic [NUMW-1:0]  dsh;
        logic [EB-1:0]    idx;
        logic signed [8:0]  diff;
        logic signed [25:0] lv;
        logic [24:0]      kk;
        logic [32:0]      mr, mg, mb;
        int unsigned      j;
        for (int unsigned k = 0; k < NST; k++) begin
            s     = (k == 0) ? '0 : r_st[(k == 0) ? 0 : k - 1];
            rw    = '0;
            pw    = '0;
            off17 = '0;
            dd    = '0;
            dsh   = '0;
            idx   = '0;
            diff  = '0;
            lv    = '0;
            kk    = '0;
            mr    = '0;
            mg    = '0;
            mb    = '0;
            j     = 0;
            if (k == 0) begin
                // capture
                s.now = i_now_ms;
                s.pix = i_pixel_index;
            end else if (k == 1) begin
                // breath and flicker set-up
                s.pix_ok   = 16'(s.pix) < PIX_LIM;
                s.b_dvd    = s.now - r_b_start;
                s.b_rem    = '0;
                s.b_off    = !b_en;
                s.b_min    = (s.now < r_b_start) || (b_per == 17'd0) ||
                             ((b_cyc != 16'd0) && (33'(s.b_dvd) >= r_b_lim));
                s.f_dvd    = s.now - r_f_start;
                s.f_rem    = '0;
                s.f_fix    = 1'b1;
                if (!f_en) begin
                    s.f_fixval = 1'b1;
                end else if (s.now < r_f_start) begin
                    s.f_fixval = 1'b0;
                end else if ((f_per == 17'd0) ||
                             ((f_cyc != 16'd0) && (33'(s.f_dvd) >= r_f_lim))) begin
                    s.f_fixval = 1'b1;
                end else begin
                    s.f_fix    = 1'b0;
                    s.f_fixval = 1'b0;
                end
                s.p_dvd    = s.pix;
                s.p_rem    = '0;
            end else if (k < ST_PH) begin
                // one restoring remainder step per stage
                rw = {s.b_rem, s.b_dvd[31]};
                if (rw >= 18'(b_per)) begin
                    rw = rw - 18'(b_per);
                end
                s.b_rem = rw[16:0];
                s.b_dvd = {s.b_dvd[30:0], 1'b0};
                rw = {s.f_rem, s.f_dvd[31]};
                if (rw >= 18'(f_per)) begin
                    rw = rw - 18'(f_per);
                end
                s.f_rem = rw[16:0];
                s.f_dvd = {s.f_dvd[30:0], 1'b0};
                if (k < ST_DIV0 + 10) begin
                    pw = {s.p_rem, s.p_dvd[9]};
                    if (pw >= 9'(grp_size)) begin
                        pw = pw - 9'(grp_size);
                    end
                    s.p_rem = pw[7:0];
                    s.p_dvd = {s.p_dvd[8:0], 1'b0};
                end
            end else if (k == ST_PH) begin
                // phase: rounded ratio numerator and divisor, flicker gate
                s.rise = s.b_rem < 17'(b_up);
                off17  = s.rise ? s.b_rem : s.b_rem - 17'(b_up);
                dd     = s.rise ? b_up : b_down;
                s.num  = (NUMW'(off17[15:0]) << EB) - NUMW'(off17[15:0]);
                s.num  = (s.num << 1) + NUMW'(dd);
                s.den  = {dd, 1'b0};
                s.q    = '0;
                s.gate = s.f_fix ? s.f_fixval :
                         ((s.f_rem < 17'(f_on)) ^ f_inv);
            end else if (k < ST_IDX) begin
                // one quotient bit per stage, top bit first
                j   = EB - 1 - (k - ST_Q0);
                dsh = NUMW'(s.den) << j;
                if (s.num >= dsh) begin
                    s.num  = s.num - dsh;
                    s.q[j] = 1'b1;
                end
            end else if (k == ST_IDX) begin
                // ease table
                idx     = s.rise ? s.q : EB'(EASE_N - 1) - s.q;
                s.entry = EASE_ROM[idx];
            end else if (k == ST_LVL) begin
                // envelope level, Q0.24
                diff = $signed({1'b0, lv_hi}) - $signed({1'b0, lv_lo});
                lv   = $signed({2'b00, lv_lo, 16'h0000}) +
                       diff * $signed({1'b0, s.entry});
                if (s.b_off) begin
                    s.level = '0;
                end else if (s.b_min) begin
                    s.level = {1'b0, lv_lo, 16'h0000};
                end else begin
                    s.level = lv[24:0];
                end
            end else begin
                // colour
                kk = s.gate ? s.level : 25'd0;
                mr = 33'(br_r) * 33'(kk);
                mg = 33'(br_g) * 33'(kk);
                mb = 33'(br_b) * 33'(kk);
                if (!(s.pix_ok && (s.p_rem < grp_lit))) begin
                    s.red   = '0;
                    s.green = '0;
                    s.blue  = '0;
                end else if (!b_en && f_en) begin
                    s.red   = s.gate ? r_f_color[23:16] : 8'd0;
                    s.green = s.gate ? r_f_color[15:8]  : 8'd0;
                    s.blue  = s.gate ? r_f_color[7:0]   : 8'd0;
                end else begin
                    s.red   = mr[31:24];
                    s.green = mg[31:24];
                    s.blue  = mb[31:24];
                end
            end
            n_st[k] = s;
        end
    end

    // Valid bits travel with the data; the whole line holds on a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int unsigned k = 0; k < NST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int unsigned k = 1; k < NST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int unsigned k = 0; k < NST; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

endmodule
`default_nettype wire
